@@ design/ffba_pkg.sv @@
// ---------------------------------------------------------------------------
// ffba_pkg
// types and constants shared by the first-fit block allocator
// ---------------------------------------------------------------------------
package ffba_pkg;

    localparam logic [1:0] ACT_ALLOC  = 2'd0;
    localparam logic [1:0] ACT_FREE   = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BADSIZE = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic [1:0] REG_MAX_REQUEST  = 2'd0;
    localparam logic [1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [1:0] REG_HEAP_LIMIT   = 2'd2;

    localparam logic [31:0] MAX_REQUEST_RST  = 32'd100000000;
    localparam logic [7:0]  HEADER_BYTES_RST = 8'd32;
    localparam logic [31:0] HEAP_LIMIT_RST   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] req_size;
        logic [31:0] block_addr;
        logic        addr_is_null;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_addr;
        logic        result_null;
        logic        copy_needed;
        logic [31:0] copy_source;
        logic [31:0] copy_length;
        logic [10:0] free_block_count;
        logic [31:0] free_byte_count;
        logic [10:0] total_block_count;
        logic [31:0] total_byte_count;
        logic [31:0] header_byte_count;
    } out_word_t;

    // classified request passed from front to back
    typedef struct packed {
        logic [1:0]  action;
        logic        bad_size;
        logic        addr_is_null;
        logic [31:0] req_size;
        logic [31:0] block_addr;
    } cmd_t;

endpackage

@@ design/ffba_front.sv @@
// ---------------------------------------------------------------------------
// ffba_front
// accepts request words, checks size, queues classified commands
// ---------------------------------------------------------------------------
module ffba_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ffba_pkg::in_word_t in_word,
    input  logic [31:0]        max_request,
    output logic               cmd_valid,
    output ffba_pkg::cmd_t     cmd,
    input  logic               cmd_take
);

    ffba_pkg::cmd_t q_reg [2];
    logic           wp_reg, wp_next;
    logic           rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    ffba_pkg::cmd_t c;
    logic           do_push;

    always_comb
    begin
        c.action       = in_word.action;
        c.addr_is_null = in_word.addr_is_null;
        c.req_size     = in_word.req_size;
        c.block_addr   = in_word.block_addr;
        c.bad_size     = (in_word.req_size == 32'd0) || (in_word.req_size > max_request);
    end

    assign full      = (cnt_reg == 2'd2);
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg ^ do_push;
        rp_next  = rp_reg ^ (cmd_take && cmd_valid);
        cnt_next = cnt_reg + {1'b0, do_push} - {1'b0, cmd_take && cmd_valid};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wp_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

@@ design/ffba_back.sv @@
// ---------------------------------------------------------------------------
// ffba_back
// walks the block table one entry at a time and updates the heap state
// ---------------------------------------------------------------------------
module ffba_back #(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  ffba_pkg::cmd_t      cmd,
    output logic                cmd_take,
    input  logic [7:0]          header_bytes,
    input  logic [31:0]         heap_limit,
    output logic                empty,
    input  logic                pop,
    output ffba_pkg::out_word_t out_word
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_FRD, S_FCHK, S_ASCAN, S_ARD, S_ACHK, S_GROW,
        S_MUL, S_DONE
    } state_t;

    logic [31:0] size_mem [MAX_BLOCKS];
    logic [31:0] off_mem  [MAX_BLOCKS];
    logic        free_mem [MAX_BLOCKS];

    state_t         state_reg;
    ffba_pkg::cmd_t c_reg;
    logic [CW-1:0]  idx_reg, cnt_reg;
    logic [AW-1:0]  hit_reg;
    logic [31:0]    hsize_reg;
    logic           hfree_reg;
    logic [31:0]    rd_size_reg, rd_off_reg;
    logic           rd_free_reg;
    logic [31:0]    heap_used_reg, free_bytes_reg, all_bytes_reg;
    logic [CW-1:0]  free_blocks_reg;
    logic           moving_reg;
    logic [1:0]     st_reg;
    logic [31:0]    raddr_reg;
    logic           copy_reg;
    logic           out_valid_reg;
    logic [42:0]    hprod_reg;
    ffba_pkg::out_word_t o_reg;

    logic [AW-1:0] ia;
    logic [32:0]   need;

    assign ia       = idx_reg[AW-1:0];
    assign need     = {1'b0, heap_used_reg} + {25'd0, header_bytes} + {1'b0, c_reg.req_size};
    assign cmd_take = (state_reg == S_IDLE) && !out_valid_reg;
    assign empty    = !out_valid_reg;
    assign out_word = o_reg;

    always_ff @(posedge clk)
    begin
        rd_size_reg <= size_mem[ia];
        rd_off_reg  <= off_mem[ia];
        rd_free_reg <= free_mem[ia];
        if (state_reg == S_GROW && cnt_reg != CW'(MAX_BLOCKS)
            && need <= {1'b0, heap_limit})
        begin
            size_mem[cnt_reg[AW-1:0]] <= c_reg.req_size;
            off_mem[cnt_reg[AW-1:0]]  <= heap_used_reg + {24'd0, header_bytes};
        end
        if (state_reg == S_GROW && cnt_reg != CW'(MAX_BLOCKS)
            && need <= {1'b0, heap_limit})
        begin
            free_mem[cnt_reg[AW-1:0]] <= 1'b0;
        end
        else if (state_reg == S_ACHK && rd_free_reg && rd_size_reg >= c_reg.req_size)
        begin
            free_mem[ia] <= 1'b0;
        end
        else if (state_reg == S_DONE && ((c_reg.action == ffba_pkg::ACT_FREE
                 && st_reg == ffba_pkg::ST_OK && !c_reg.addr_is_null) || copy_reg))
        begin
            free_mem[hit_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            heap_used_reg   <= '0;
            free_bytes_reg  <= '0;
            all_bytes_reg   <= '0;
            free_blocks_reg <= '0;
            out_valid_reg   <= 1'b0;
            moving_reg      <= 1'b0;
            copy_reg        <= 1'b0;
            st_reg          <= ffba_pkg::ST_OK;
        end
        else
        begin
            if (out_valid_reg && pop)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_take)
                    begin
                        c_reg      <= cmd;
                        idx_reg    <= '0;
                        st_reg     <= ffba_pkg::ST_OK;
                        raddr_reg  <= '0;
                        copy_reg   <= 1'b0;
                        moving_reg <= 1'b0;
                        case (cmd.action)
                            ffba_pkg::ACT_ALLOC:
                            begin
                                if (cmd.bad_size)
                                begin
                                    st_reg    <= ffba_pkg::ST_BADSIZE;
                                    state_reg <= S_MUL;
                                end
                                else
                                begin
                                    state_reg <= S_ASCAN;
                                end
                            end
                            ffba_pkg::ACT_FREE:
                            begin
                                state_reg <= cmd.addr_is_null ? S_MUL : S_FIND;
                            end
                            ffba_pkg::ACT_RESIZE:
                            begin
                                if (cmd.bad_size)
                                begin
                                    st_reg    <= ffba_pkg::ST_BADSIZE;
                                    state_reg <= S_MUL;
                                end
                                else if (cmd.addr_is_null)
                                begin
                                    state_reg <= S_ASCAN;
                                end
                                else
                                begin
                                    state_reg <= S_FIND;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_MUL;
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (idx_reg == cnt_reg)
                    begin
                        st_reg    <= ffba_pkg::ST_UNKNOWN;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        state_reg <= S_FRD;
                    end
                end
                S_FRD:
                begin
                    state_reg <= S_FCHK;
                end
                S_FCHK:
                begin
                    if (rd_off_reg == c_reg.block_addr)
                    begin
                        hit_reg   <= ia;
                        hsize_reg <= rd_size_reg;
                        hfree_reg <= rd_free_reg;
                        if (c_reg.action == ffba_pkg::ACT_FREE)
                        begin
                            if (!rd_free_reg)
                            begin
                                free_blocks_reg <= free_blocks_reg + CW'(1);
                                free_bytes_reg  <= free_bytes_reg + rd_size_reg;
                            end
                            state_reg <= S_MUL;
                        end
                        else if (rd_size_reg >= c_reg.req_size)
                        begin
                            raddr_reg <= c_reg.block_addr;
                            state_reg <= S_MUL;
                        end
                        else
                        begin
                            moving_reg <= 1'b1;
                            idx_reg    <= '0;
                            state_reg  <= S_ASCAN;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_FIND;
                    end
                end
                S_ASCAN:
                begin
                    state_reg <= (idx_reg == cnt_reg) ? S_GROW : S_ARD;
                end
                S_ARD:
                begin
                    state_reg <= S_ACHK;
                end
                S_ACHK:
                begin
                    if (rd_free_reg && rd_size_reg >= c_reg.req_size)
                    begin
                        free_blocks_reg <= free_blocks_reg - CW'(1);
                        free_bytes_reg  <= free_bytes_reg - rd_size_reg;
                        raddr_reg       <= rd_off_reg;
                        if (moving_reg)
                        begin
                            copy_reg <= 1'b1;
                        end
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_ASCAN;
                    end
                end
                S_GROW:
                begin
                    if (cnt_reg == CW'(MAX_BLOCKS) || need > {1'b0, heap_limit})
                    begin
                        st_reg <= ffba_pkg::ST_FULL;
                    end
                    else
                    begin
                        raddr_reg     <= heap_used_reg + {24'd0, header_bytes};
                        cnt_reg       <= cnt_reg + CW'(1);
                        heap_used_reg <= need[31:0];
                        all_bytes_reg <= all_bytes_reg + c_reg.req_size;
                        if (moving_reg)
                        begin
                            copy_reg <= 1'b1;
                        end
                    end
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    hprod_reg <= 43'(cnt_reg) * 43'(header_bytes);
                    // old block freed after a successful move
                    if (copy_reg && !hfree_reg)
                    begin
                        free_blocks_reg <= free_blocks_reg + CW'(1);
                        free_bytes_reg  <= free_bytes_reg + hsize_reg;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    o_reg.status      <= st_reg;
                    o_reg.result_null <= (c_reg.action == ffba_pkg::ACT_FREE) ? 1'b0
                                         : (st_reg != ffba_pkg::ST_OK
                                            || c_reg.action == ffba_pkg::ACT_NONE);
                    o_reg.result_addr <= (c_reg.action == ffba_pkg::ACT_ALLOC
                                          || c_reg.action == ffba_pkg::ACT_RESIZE)
                                         && st_reg == ffba_pkg::ST_OK ? raddr_reg : 32'd0;
                    o_reg.copy_needed <= copy_reg;
                    o_reg.copy_source <= copy_reg ? c_reg.block_addr : 32'd0;
                    o_reg.copy_length <= copy_reg ? hsize_reg : 32'd0;
                    o_reg.free_block_count  <= 11'(free_blocks_reg);
                    o_reg.free_byte_count   <= free_bytes_reg;
                    o_reg.total_block_count <= 11'(cnt_reg);
                    o_reg.total_byte_count  <= all_bytes_reg;
                    o_reg.header_byte_count <= hprod_reg[31:0];
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/first_fit_block_allocator.sv @@
// ---------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit heap block allocator without block splitting
// ---------------------------------------------------------------------------
// requests enter with push/full as an in_word of action, size and address;
// results leave with empty/pop as one out_word per request, in order.
// the front checks the size and holds up to two requests in a small queue,
// so it keeps accepting while the back works on the previous request.
// the back walks the block table one entry at a time (index, table read,
// compare) for a free lookup or first-fit scan over n blocks; a resize
// that moves walks both.
// requests are carried out one at a time; the result sits in an output
// register until popped, and the back waits on it while the front fills.
// configuration registers are written through cfg_we/cfg_index/cfg_data by
// the user only while idle; the block itself does not enforce this. reset
// empties the table and counts and restores the register defaults; the table memory itself is not cleared.
// ---------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  ffba_pkg::in_word_t  in_word,
    output logic                empty,
    input  logic                pop,
    output ffba_pkg::out_word_t out_word,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [31:0]    max_request_reg;
    logic [7:0]     header_bytes_reg;
    logic [31:0]    heap_limit_reg;
    logic           cmd_valid;
    logic           cmd_take;
    ffba_pkg::cmd_t cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_request_reg  <= ffba_pkg::MAX_REQUEST_RST;
            header_bytes_reg <= ffba_pkg::HEADER_BYTES_RST;
            heap_limit_reg   <= ffba_pkg::HEAP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ffba_pkg::REG_MAX_REQUEST:  max_request_reg  <= cfg_data;
                ffba_pkg::REG_HEADER_BYTES: header_bytes_reg <= cfg_data[7:0];
                ffba_pkg::REG_HEAP_LIMIT:   heap_limit_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    ffba_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_word     (in_word),
        .max_request (max_request_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_take    (cmd_take)
    );

    ffba_back #(.MAX_BLOCKS(MAX_BLOCKS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .header_bytes (header_bytes_reg),
        .heap_limit   (heap_limit_reg),
        .empty        (empty),
        .pop          (pop),
        .out_word     (out_word)
    );

endmodule

@@ design/ffba_checker.sv @@
// ---------------------------------------------------------------------------
// ffba_checker
// port-level checks for the first-fit block allocator
// ---------------------------------------------------------------------------
module ffba_checker
(
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input ffba_pkg::out_word_t out_word
);

    a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(out_word))
        else $error("result word changed while waiting");

    a_null_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.result_null) |-> (out_word.result_addr == 32'd0))
        else $error("null result with nonzero address");

    a_copy_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_word.copy_needed) |-> (out_word.status == ffba_pkg::ST_OK))
        else $error("copy reported on failed request");

    a_free_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_word.free_block_count <= out_word.total_block_count))
        else $error("more free blocks than blocks");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_word (out_word)
);
